>>> design/rpc_pkg.sv
// rpc_pkg: shared types and constants for the record payload checker.
// Holds the phase codes, status codes, parser state and result beat structs.
// No dependencies.
package rpc_pkg;

	// Parse phase, which doubles as the part code on each result beat
	typedef enum logic [2:0] {
		PH_MAGIC   = 3'd0,
		PH_COUNT   = 3'd1,
		PH_NAMELEN = 3'd2,
		PH_NAME    = 3'd3,
		PH_KIND    = 3'd4,
		PH_VALLEN  = 3'd5,
		PH_VALUE   = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	// Part code for bytes after the parse has ended or failed
	localparam logic [2:0] PART_DISCARD = 3'd7;

	// Status codes
	localparam logic [2:0] ST_PROGRESS     = 3'd0;
	localparam logic [2:0] ST_ACCEPTED     = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
	localparam logic [2:0] ST_TRUNCATED    = 3'd3;
	localparam logic [2:0] ST_EMPTY_NAME   = 3'd4;
	localparam logic [2:0] ST_UNKNOWN_KIND = 3'd5;
	localparam logic [2:0] ST_TRAILING     = 3'd6;

	// Value kinds
	localparam logic [2:0] KIND_NULL    = 3'd0;
	localparam logic [2:0] KIND_INTEGER = 3'd1;
	localparam logic [2:0] KIND_REAL    = 3'd2;
	localparam logic [2:0] KIND_TEXT    = 3'd3;
	localparam logic [2:0] KIND_BINARY  = 3'd4;

	// Fixed value length of integer and real fields
	localparam logic [31:0] FIXED_VALUE_LEN = 32'd8;

	// Magic sequence 'S' 'Q' 'F' '1'
	localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h51, 8'h46, 8'h31};

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  byte_idx;      // byte position inside a multi-byte part
		logic [31:0] bytes_left;    // length being gathered, or bytes still due
		logic [31:0] fields_left;
		logic [31:0] field_counter;
		logic [2:0]  cur_kind;
		logic [2:0]  err;           // sticky first error, ST_PROGRESS if none
	} rpc_state_t;

	localparam rpc_state_t RESET_STATE = '{
		phase:         PH_MAGIC,
		byte_idx:      2'd0,
		bytes_left:    32'd4,
		fields_left:   32'd0,
		field_counter: 32'd0,
		cur_kind:      KIND_NULL,
		err:           ST_PROGRESS
	};

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  part;
		logic [31:0] field_number;
		logic [2:0]  value_kind;
		logic        field_done;
		logic        payload_done;
		logic [2:0]  status;
	} rpc_result_t;

endpackage

>>> design/rpc_parse.sv
// rpc_parse: per-byte parse step, combinational.
// Computes the next parser state and the tagged result for one byte.
// Depends on rpc_pkg.
module rpc_parse (
	input  rpc_pkg::rpc_state_t  cur,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output rpc_pkg::rpc_state_t  nxt,
	output rpc_pkg::rpc_result_t res
);
	import rpc_pkg::*;

	logic [31:0] placed;
	logic        finish;

	// Byte moved to its little-endian position within a length word
	assign placed = {24'd0, data_byte} << {cur.byte_idx, 3'b000};

	always_comb begin
		nxt              = cur;
		finish           = 1'b0;
		res.byte_out     = data_byte;
		res.part         = PART_DISCARD;
		res.field_number = cur.field_counter;
		res.value_kind   = KIND_NULL;
		res.field_done   = 1'b0;
		res.payload_done = final_byte;
		res.status       = ST_PROGRESS;

		if (cur.err != ST_PROGRESS) begin
			// error held: byte is discarded
		end else if (cur.phase == PH_DONE) begin
			nxt.err = ST_TRAILING;
		end else begin
			res.part = cur.phase;
			case (cur.phase)
				PH_MAGIC: begin
					res.field_number = 32'd0;
					if (data_byte != MAGIC[cur.byte_idx]) begin
						nxt.err = ST_BAD_MAGIC;
					end else begin
						nxt.byte_idx = cur.byte_idx + 2'd1;
						if (cur.byte_idx == 2'd3) begin
							nxt.phase       = PH_COUNT;
							nxt.byte_idx    = 2'd0;
							nxt.fields_left = 32'd0;
						end
					end
				end
				PH_COUNT: begin
					res.field_number = 32'd0;
					nxt.fields_left  = cur.fields_left | placed;
					nxt.byte_idx     = cur.byte_idx + 2'd1;
					if (cur.byte_idx == 2'd3) begin
						nxt.field_counter = 32'd0;
						if ((cur.fields_left | placed) == 32'd0) begin
							nxt.phase = PH_DONE;
						end else begin
							nxt.phase      = PH_NAMELEN;
							nxt.byte_idx   = 2'd0;
							nxt.bytes_left = 32'd0;
							nxt.cur_kind   = KIND_NULL;
						end
					end
				end
				PH_NAMELEN: begin
					nxt.bytes_left = cur.bytes_left | placed;
					nxt.byte_idx   = cur.byte_idx + 2'd1;
					if (cur.byte_idx == 2'd1) begin
						if ((cur.bytes_left | placed) == 32'd0)
							nxt.err = ST_EMPTY_NAME;
						else
							nxt.phase = PH_NAME;
					end
				end
				PH_NAME: begin
					nxt.bytes_left = cur.bytes_left - 32'd1;
					if (cur.bytes_left == 32'd1)
						nxt.phase = PH_KIND;
				end
				PH_KIND: begin
					if (data_byte > {5'd0, KIND_BINARY}) begin
						nxt.err = ST_UNKNOWN_KIND;
					end else begin
						nxt.cur_kind   = data_byte[2:0];
						res.value_kind = data_byte[2:0];
						if (data_byte[2:0] == KIND_NULL) begin
							finish = 1'b1;
						end else if (data_byte[2:0] <= KIND_REAL) begin
							nxt.phase      = PH_VALUE;
							nxt.bytes_left = FIXED_VALUE_LEN;
						end else begin
							nxt.phase      = PH_VALLEN;
							nxt.byte_idx   = 2'd0;
							nxt.bytes_left = 32'd0;
						end
					end
				end
				PH_VALLEN: begin
					res.value_kind = cur.cur_kind;
					nxt.bytes_left = cur.bytes_left | placed;
					nxt.byte_idx   = cur.byte_idx + 2'd1;
					if (cur.byte_idx == 2'd3) begin
						if ((cur.bytes_left | placed) == 32'd0)
							finish = 1'b1;
						else
							nxt.phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					res.value_kind = cur.cur_kind;
					nxt.bytes_left = cur.bytes_left - 32'd1;
					if (cur.bytes_left == 32'd1)
						finish = 1'b1;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end

		// Field complete: move to the next field or to the end
		if (finish) begin
			res.field_done    = 1'b1;
			nxt.fields_left   = cur.fields_left - 32'd1;
			nxt.field_counter = cur.field_counter + 32'd1;
			if (cur.fields_left == 32'd1) begin
				nxt.phase = PH_DONE;
			end else begin
				nxt.phase      = PH_NAMELEN;
				nxt.byte_idx   = 2'd0;
				nxt.bytes_left = 32'd0;
				nxt.cur_kind   = KIND_NULL;
			end
		end

		// Status of this beat
		if (nxt.err != ST_PROGRESS)
			res.status = nxt.err;
		else if (final_byte)
			res.status = (nxt.phase == PH_DONE) ? ST_ACCEPTED : ST_TRUNCATED;

		// Final byte returns the parser to its reset state
		if (final_byte)
			nxt = RESET_STATE;
	end

endmodule

>>> design/rpc_out_stage.sv
// rpc_out_stage: result register with valid/ready handshake.
// Takes a new beat whenever empty or being drained in the same cycle.
// Depends on rpc_pkg.
module rpc_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  rpc_pkg::rpc_result_t res_in,
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rpc_pkg::rpc_result_t res_out
);
	import rpc_pkg::*;

	logic        valid_q;
	rpc_result_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// Result beat, no reset needed
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

endmodule

>>> design/record_payload_checker.sv
// record_payload_checker: byte-serial record payload checker.
// Each accepted input beat's result is registered and valid in the following cycle.
// Throughput: one byte per cycle unless out_ready stalls; state updates in one step.
// Reset: arst_n clears the parser to the magic phase and empties the result register.
// The parser also returns to its reset state after every final byte.
module record_payload_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic [2:0]  part,
	output logic [31:0] field_number,
	output logic [2:0]  value_kind,
	output logic        field_done,
	output logic        payload_done,
	output logic [2:0]  status
);
	import rpc_pkg::*;

	rpc_state_t  state_q;
	rpc_state_t  state_nxt;
	rpc_result_t res_nxt;
	rpc_result_t res_out;
	logic        accept;

	assign accept = in_valid && in_ready;

	rpc_parse u_parse (
		.cur        (state_q),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= RESET_STATE;
		else if (accept)
			state_q <= state_nxt;
	end

	rpc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_in    (res_nxt),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign byte_out     = res_out.byte_out;
	assign part         = res_out.part;
	assign field_number = res_out.field_number;
	assign value_kind   = res_out.value_kind;
	assign field_done   = res_out.field_done;
	assign payload_done = res_out.payload_done;
	assign status       = res_out.status;

endmodule

>>> design/rpc_checker.sv
// rpc_checker: port-level assertions for record_payload_checker, and its bind.
// Depends on rpc_pkg.
module rpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  byte_out,
	input logic [2:0]  part,
	input logic [31:0] field_number,
	input logic [2:0]  value_kind,
	input logic        field_done,
	input logic        payload_done,
	input logic [2:0]  status
);
	import rpc_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status)
			&& $stable(field_number))
		else $error("result beat changed while stalled");

	// Every accepted byte yields a result beat in the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted byte produced no result");

	// Magic and count bytes carry field zero and no kind
	a_header_tags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (part == PH_MAGIC || part == PH_COUNT)
			|-> field_number == 32'd0 && value_kind == KIND_NULL)
		else $error("header byte carries field tags");

	// A field ends only on a kind, value length or value byte, never with an error
	a_field_done_part: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_done |-> (part == PH_KIND || part == PH_VALLEN
			|| part == PH_VALUE) && (status == ST_PROGRESS || status == ST_ACCEPTED
			|| status == ST_TRUNCATED))
		else $error("field completed on wrong part");

	// Accepted status only on the final byte
	a_accept_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ACCEPTED |-> payload_done)
		else $error("accepted status before final byte");

endmodule

bind record_payload_checker rpc_checker u_rpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.byte_out     (byte_out),
	.part         (part),
	.field_number (field_number),
	.value_kind   (value_kind),
	.field_done   (field_done),
	.payload_done (payload_done),
	.status       (status)
);

>>> tb/sv/record_payload_checker_test.sv
`timescale 1ns / 100ps
// record_payload_checker_test: self-checking testbench for the record payload checker.
// Predicts the tag of every byte beat and compares each result beat field by field.
// Depends on rpc_pkg and record_payload_checker.
module record_payload_checker_test;
	import rpc_pkg::*;

	// Ways a generated payload can be spoilt
	typedef enum int {
		FLAW_NONE, FLAW_MAGIC, FLAW_TRUNCATE, FLAW_EMPTY_NAME,
		FLAW_BAD_KIND, FLAW_TRAILING, FLAW_OVERCOUNT, FLAW_NOISE
	} flaw_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} feed_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte_out;
	logic [2:0]  part;
	logic [31:0] field_number;
	logic [2:0]  value_kind;
	logic        field_done;
	logic        payload_done;
	logic [2:0]  status;

	feed_byte_t  byte_feed [$];
	rpc_result_t pending_tags [$];
	logic [7:0]  build_buf [$];
	int unsigned kind_at [$];
	int unsigned namelen_at [$];

	logic        in_taken = 1'b0;
	logic        failed = 1'b0;
	int unsigned cyc = 0;
	logic        calm;

	// Predictor state of the parser
	phase_t      prs_phase;
	logic [31:0] prs_left;
	logic [31:0] prs_shift;
	logic [31:0] prs_fields_left;
	logic [31:0] prs_field_idx;
	logic [2:0]  prs_kind;
	logic [2:0]  prs_err;

	record_payload_checker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.final_byte   (final_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_out     (byte_out),
		.part         (part),
		.field_number (field_number),
		.value_kind   (value_kind),
		.field_done   (field_done),
		.payload_done (payload_done),
		.status       (status)
	);

	always #4 clk = ~clk;

	// No idling on either side in this window of cycles
	assign calm = (cyc >= 800) && (cyc < 1400);

	// ---------------------------------------------------------------
	// Parser predictor
	// ---------------------------------------------------------------
	function void parser_clear();
		prs_phase       = PH_MAGIC;
		prs_left        = 32'd4;
		prs_shift       = 32'd0;
		prs_fields_left = 32'd0;
		prs_field_idx   = 32'd0;
		prs_kind        = KIND_NULL;
		prs_err         = ST_PROGRESS;
	endfunction

	function void begin_field();
		prs_phase = PH_NAMELEN;
		prs_shift = 32'd0;
		prs_left  = 32'd0;
		prs_kind  = KIND_NULL;
	endfunction

	function void end_field();
		prs_fields_left = prs_fields_left - 32'd1;
		prs_field_idx   = prs_field_idx + 32'd1;
		if (prs_fields_left == 32'd0)
			prs_phase = PH_DONE;
		else
			begin_field();
	endfunction

	function rpc_result_t tag_byte(input logic [7:0] b, input logic fin);
		rpc_result_t r;
		logic [1:0]  slot;
		r.byte_out     = b;
		r.part         = PART_DISCARD;
		r.field_number = prs_field_idx;
		r.value_kind   = KIND_NULL;
		r.field_done   = 1'b0;
		r.payload_done = fin;
		r.status       = ST_PROGRESS;
		if (prs_err != ST_PROGRESS) begin
			r.part = PART_DISCARD;
		end else if (prs_phase == PH_DONE) begin
			prs_err = ST_TRAILING;
		end else begin
			r.part = prs_phase;
			case (prs_phase)
				PH_MAGIC: begin
					r.field_number = 32'd0;
					slot = 2'(32'd4 - prs_left);
					if (b != MAGIC[slot]) begin
						prs_err = ST_BAD_MAGIC;
					end else begin
						prs_left = prs_left - 32'd1;
						if (prs_left == 32'd0) begin
							prs_phase       = PH_COUNT;
							prs_shift       = 32'd0;
							prs_fields_left = 32'd0;
						end
					end
				end
				PH_COUNT: begin
					r.field_number  = 32'd0;
					prs_fields_left = prs_fields_left | (32'(b) << prs_shift[4:0]);
					prs_shift       = prs_shift + 32'd8;
					if (prs_shift >= 32'd32) begin
						prs_field_idx = 32'd0;
						if (prs_fields_left == 32'd0)
							prs_phase = PH_DONE;
						else
							begin_field();
					end
				end
				PH_NAMELEN: begin
					prs_left  = prs_left | (32'(b) << prs_shift[4:0]);
					prs_shift = prs_shift + 32'd8;
					if (prs_shift >= 32'd16) begin
						if (prs_left == 32'd0)
							prs_err = ST_EMPTY_NAME;
						else
							prs_phase = PH_NAME;
					end
				end
				PH_NAME: begin
					prs_left = prs_left - 32'd1;
					if (prs_left == 32'd0)
						prs_phase = PH_KIND;
				end
				PH_KIND: begin
					if (b > KIND_BINARY) begin
						prs_err = ST_UNKNOWN_KIND;
					end else begin
						prs_kind     = b[2:0];
						r.value_kind = b[2:0];
						if (b[2:0] == KIND_NULL) begin
							r.field_done = 1'b1;
							end_field();
						end else if (b[2:0] <= KIND_REAL) begin
							prs_phase = PH_VALUE;
							prs_left  = FIXED_VALUE_LEN;
						end else begin
							prs_phase = PH_VALLEN;
							prs_shift = 32'd0;
							prs_left  = 32'd0;
						end
					end
				end
				PH_VALLEN: begin
					r.value_kind = prs_kind;
					prs_left     = prs_left | (32'(b) << prs_shift[4:0]);
					prs_shift    = prs_shift + 32'd8;
					if (prs_shift >= 32'd32) begin
						if (prs_left == 32'd0) begin
							r.field_done = 1'b1;
							end_field();
						end else begin
							prs_phase = PH_VALUE;
						end
					end
				end
				default: begin
					r.value_kind = prs_kind;
					prs_left     = prs_left - 32'd1;
					if (prs_left == 32'd0) begin
						r.field_done = 1'b1;
						end_field();
					end
				end
			endcase
		end
		if (prs_err != ST_PROGRESS)
			r.status = prs_err;
		else if (fin)
			r.status = (prs_phase == PH_DONE) ? ST_ACCEPTED : ST_TRUNCATED;
		// final byte ends the payload, parser starts afresh
		if (fin)
			parser_clear();
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Payload building
	// ---------------------------------------------------------------
	// Append one byte to the payload under construction
	function void add_byte(input logic [7:0] b);
		build_buf.insert(build_buf.size(), b);
	endfunction

	function void put_le(input logic [31:0] v, input int unsigned n);
		for (int i = 0; i < n; i++)
			add_byte(v[8*i +: 8]);
	endfunction

	function void put_header(input logic [31:0] count);
		build_buf.delete();
		kind_at.delete();
		namelen_at.delete();
		for (int i = 0; i < 4; i++)
			add_byte(MAGIC[i]);
		put_le(count, 4);
	endfunction

	// body: value bytes actually appended after a length prefix
	function void put_field(input logic [2:0] kind, input int unsigned name_len,
			input logic [31:0] val_len, input int unsigned body);
		namelen_at.insert(namelen_at.size(), build_buf.size());
		put_le(32'(name_len), 2);
		repeat (name_len) add_byte(8'($urandom));
		kind_at.insert(kind_at.size(), build_buf.size());
		add_byte(8'(kind));
		if (kind == KIND_NULL) begin
		end else if (kind <= KIND_REAL) begin
			repeat (FIXED_VALUE_LEN) add_byte(8'($urandom));
		end else begin
			put_le(val_len, 4);
			repeat (body) add_byte(8'($urandom));
		end
	endfunction

	// Queue the first keep bytes, flagging the last as final
	function void commit(input int unsigned keep);
		feed_byte_t fb;
		for (int i = 0; i < keep; i++) begin
			fb.data = build_buf[i];
			fb.fin  = (i == keep - 1);
			byte_feed.insert(byte_feed.size(), fb);
		end
	endfunction

	function void random_payload();
		int unsigned n;
		int unsigned keep;
		int unsigned p;
		int unsigned val_len;
		flaw_t       flaw;
		n    = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
		flaw = ($urandom_range(99) < 65) ? FLAW_NONE
			: flaw_t'($urandom_range(FLAW_MAGIC, FLAW_NOISE));
		put_header((flaw == FLAW_OVERCOUNT) ? n + $urandom_range(1, 3) : n);
		for (int i = 0; i < n; i++) begin
			val_len = $urandom_range(0, 6);
			put_field(3'($urandom_range(KIND_NULL, KIND_BINARY)),
				($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4),
				val_len, val_len);
		end
		keep = build_buf.size();
		case (flaw)
			FLAW_MAGIC: begin
				p = $urandom_range(3);
				build_buf[p] = build_buf[p] ^ 8'($urandom_range(1, 255));
			end
			FLAW_TRUNCATE: keep = $urandom_range(1, build_buf.size() - 1);
			FLAW_EMPTY_NAME: if (namelen_at.size() != 0) begin
				p = namelen_at[$urandom_range(namelen_at.size() - 1)];
				build_buf[p]     = 8'd0;
				build_buf[p + 1] = 8'd0;
			end
			FLAW_BAD_KIND: if (kind_at.size() != 0) begin
				p = kind_at[$urandom_range(kind_at.size() - 1)];
				build_buf[p] = 8'($urandom_range(5, 255));
			end
			FLAW_TRAILING: begin
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
				keep = build_buf.size();
			end
			FLAW_NOISE: begin
				build_buf.delete();
				repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
				keep = build_buf.size();
			end
			default: ;
		endcase
		commit(keep);
	endfunction

	// ---------------------------------------------------------------
	// Acceptance, prediction and result checking
	// ---------------------------------------------------------------
	function void check_tag(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		rpc_result_t want;
		cyc      <= cyc + 1;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			pending_tags.insert(pending_tags.size(), tag_byte(data_byte, final_byte));
		if (arst_n && out_valid && out_ready) begin
			if (pending_tags.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, actual byte %0h",
					$time, byte_out);
				failed = 1'b1;
			end else begin
				want = pending_tags.pop_front();
				check_tag("byte_out", 32'(want.byte_out), 32'(byte_out));
				check_tag("part", 32'(want.part), 32'(part));
				check_tag("field_number", want.field_number, field_number);
				check_tag("value_kind", 32'(want.value_kind), 32'(value_kind));
				check_tag("field_done", 32'(want.field_done), 32'(field_done));
				check_tag("payload_done", 32'(want.payload_done), 32'(payload_done));
				check_tag("status", 32'(want.status), 32'(status));
			end
		end
	end

	// Driver: next byte beat and output stall, both at the falling edge
	always @(negedge clk) begin
		feed_byte_t nb;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
					nb = byte_feed.pop_front();
					in_valid   <= 1'b1;
					data_byte  <= nb.data;
					final_byte <= nb.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		parser_clear();

		// zero fields, complete right after the count
		put_header(32'd0);
		commit(build_buf.size());
		// every kind, binary with an empty value
		put_header(32'd5);
		put_field(KIND_NULL, 1, 32'd0, 0);
		put_field(KIND_INTEGER, 1, 32'd0, 0);
		put_field(KIND_REAL, 2, 32'd0, 0);
		put_field(KIND_TEXT, 1, 32'd3, 3);
		put_field(KIND_BINARY, 1, 32'd0, 0);
		commit(build_buf.size());
		// short payload with a wrong second magic byte, then one cut short
		build_buf.delete();
		add_byte(MAGIC[0]);
		add_byte(8'hFF);
		commit(2);
		commit(1);
		// bytes after an error are discarded with the error held
		build_buf.delete();
		add_byte(8'h00);
		repeat (3) add_byte(MAGIC[1]);
		commit(4);
		// huge field count runs into truncation
		put_header(32'hFFFF_FFFF);
		put_field(KIND_NULL, 1, 32'd0, 0);
		commit(build_buf.size());
		// empty name
		put_header(32'd1);
		put_field(KIND_NULL, 1, 32'd0, 0);
		build_buf[namelen_at[0]]     = 8'd0;
		build_buf[namelen_at[0] + 1] = 8'd0;
		commit(build_buf.size());
		// unknown kinds, just past the last and the top value
		put_header(32'd1);
		put_field(KIND_NULL, 1, 32'd0, 0);
		build_buf[kind_at[0]] = 8'd5;
		commit(build_buf.size());
		build_buf[kind_at[0]] = 8'hFF;
		commit(build_buf.size());
		// trailing byte after a zero-field count
		put_header(32'd0);
		add_byte(8'hA5);
		commit(build_buf.size());
		// long name, then the largest value length cut short
		put_header(32'd2);
		put_field(KIND_BINARY, 256, 32'd1, 1);
		put_field(KIND_BINARY, 1, 32'hFFFF_FFFF, 2);
		commit(build_buf.size());

		while (byte_feed.size() < 1650)
			random_payload();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || in_valid || pending_tags.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> record_payload_checker.f
design/rpc_pkg.sv
design/rpc_parse.sv
design/rpc_out_stage.sv
design/record_payload_checker.sv
design/rpc_checker.sv
tb/sv/record_payload_checker_test.sv
